FILE: design/lru_cache_with_expiry_top_macros.svh
// Assertion helpers shared by the modules that check themselves.
`ifndef LRU_CACHE_WITH_EXPIRY_TOP_MACROS_SVH
`define LRU_CACHE_WITH_EXPIRY_TOP_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define LRUE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lru cache check failed");

// Checks that a condition in one cycle is followed by another in the next.
`define LRUE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru cache check failed");

`endif

FILE: design/lrue_pkg.sv
// ----------------------------------------------------------------------------
// LRU cache with expiry: shared package
// Operation codes, engine states, widths and the configuration bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrue_pkg;

  localparam int OP_BITS   = 3;
  localparam int SECS_BITS = 16;
  localparam int TPS_BITS  = 21;
  localparam int CAP_BITS  = 5;
  localparam int CFG_BITS  = 21;
  localparam int TIME_BITS = 48;
  localparam int CNT_BITS  = 32;
  localparam int PROD_BITS = SECS_BITS + TPS_BITS;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
  localparam logic [TPS_BITS-1:0] TPS_RESET = 21'd1;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_TICKS    = 1'b1;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUT    = 3'd0,
    OP_GET    = 3'd1,
    OP_ERASE  = 3'd2,
    OP_EXISTS = 3'd3,
    OP_EXPIRE = 3'd4,
    OP_TICK   = 3'd5,
    OP_NOP    = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PURGE,
    ST_EXEC,
    ST_EXPIRE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CAP_BITS-1:0] capacity;
    logic [TPS_BITS-1:0] tps;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/lru_cache_with_expiry_top.sv
// ----------------------------------------------------------------------------
// LRU cache with expiry: top level
// Fully associative key/value store with LRU replacement and entry expiry.
// ----------------------------------------------------------------------------
// Commands enter on the input channel (in_valid, in_stall) with operation,
// lookup_key, value_in and seconds. Each command yields one result on the
// output channel (out_valid, out_stall) with found, value_out and the hit
// and miss counters as they stand after the command.
// The front end decodes each command into a two-entry queue, so it keeps
// taking transfers while the engine works. The engine runs one command at a
// time: put and get first purge the expired entries one by one, put then
// evicts least recently used entries one by one while the store is at
// capacity for a new key, and expiry writes the new expiry time in a
// further step. The engine's single shared update of the ranks and entries
// is why purges and evictions go one entry at a time.
// Reset empties the store, clears ranks, time and counters and sets the
// capacity to 16 and the tick rate to 1. Configuration writes take effect
// at once. When the receiver stalls, the result is held, the engine waits
// with the next result and the queue fills, then in_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_cache_with_expiry_top_macros.svh"

module lru_cache_with_expiry_top #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [lrue_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lrue_pkg::OP_BITS-1:0]   operation,
  input  logic [KEY_BITS-1:0]            lookup_key,
  input  logic [VALUE_BITS-1:0]          value_in,
  input  logic [lrue_pkg::SECS_BITS-1:0] seconds,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           found,
  output logic [VALUE_BITS-1:0]          value_out,
  output logic [lrue_pkg::CNT_BITS-1:0]  hit_count,
  output logic [lrue_pkg::CNT_BITS-1:0]  miss_count
);

  import lrue_pkg::*;

  localparam int QW = OP_BITS + KEY_BITS + VALUE_BITS + SECS_BITS;

  cfg_t            cfg;
  op_t             op_dec;
  logic [QW-1:0]   q_in;
  logic [QW-1:0]   q_out;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity <= CAP_RESET;
      cfg.tps      <= TPS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CAPACITY) begin
        cfg.capacity <= cfg_data[CAP_BITS-1:0];
      end else begin
        cfg.tps <= cfg_data[TPS_BITS-1:0];
      end
    end
  end

  always_comb begin
    case (operation)
      OP_PUT:    op_dec = OP_PUT;
      OP_GET:    op_dec = OP_GET;
      OP_ERASE:  op_dec = OP_ERASE;
      OP_EXISTS: op_dec = OP_EXISTS;
      OP_EXPIRE: op_dec = OP_EXPIRE;
      OP_TICK:   op_dec = OP_TICK;
      default:   op_dec = OP_NOP;
    endcase
  end

  assign q_in     = {op_dec, lookup_key, value_in, seconds};
  assign in_stall = q_full;

  lrue_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  lrue_engine #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_valid  (q_valid),
    .cmd_op     (op_t'(q_out[QW-1 -: OP_BITS])),
    .cmd_key    (q_out[KEY_BITS + VALUE_BITS + SECS_BITS - 1 -: KEY_BITS]),
    .cmd_value  (q_out[VALUE_BITS + SECS_BITS - 1 -: VALUE_BITS]),
    .cmd_secs   (q_out[SECS_BITS-1:0]),
    .cmd_pop    (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .value_out  (value_out),
    .hit_count  (hit_count),
    .miss_count (miss_count)
  );

  `LRUE_ASSERT(a_full_has_data, !in_stall || q_valid)
  `LRUE_ASSERT(a_miss_zero_value, !(out_valid && !found) || value_out == '0)
  `LRUE_ASSERT_NEXT(a_hits_grow, out_valid, !out_valid || hit_count >= $past(hit_count))
  `LRUE_ASSERT_NEXT(a_misses_grow, out_valid, !out_valid || miss_count >= $past(miss_count))

endmodule

`default_nettype wire

FILE: design/lrue_queue.sv
// ----------------------------------------------------------------------------
// LRU cache with expiry: command queue
// Two-entry queue between the front end and the execution engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrue_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic [1:0]       fill_next;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = slots[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + 2'd1;
    end else if (pop && !push) begin
      fill_next = fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/lrue_engine.sv
// ----------------------------------------------------------------------------
// LRU cache with expiry: execution engine
// Holds the entries, recency ranks and time, and carries out one command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrue_engine #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lrue_pkg::cfg_t                  cfg,
  input  logic                            cmd_valid,
  input  lrue_pkg::op_t                   cmd_op,
  input  logic [KEY_BITS-1:0]             cmd_key,
  input  logic [VALUE_BITS-1:0]           cmd_value,
  input  logic [lrue_pkg::SECS_BITS-1:0]  cmd_secs,
  output logic                            cmd_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [VALUE_BITS-1:0]           value_out,
  output logic [lrue_pkg::CNT_BITS-1:0]   hit_count,
  output logic [lrue_pkg::CNT_BITS-1:0]   miss_count
);

  import lrue_pkg::*;

  localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [CNT_BITS-1:0]  CNT_MAX  = '1;

  state_t state;
  state_t state_next;

  logic                  valid    [DEPTH];
  logic [KEY_BITS-1:0]   keys     [DEPTH];
  logic [VALUE_BITS-1:0] vals     [DEPTH];
  logic                  exp_set  [DEPTH];
  logic [TIME_BITS-1:0]  exp_time [DEPTH];
  logic [RW-1:0]         rank     [DEPTH];
  logic [CW-1:0]         count;
  logic [TIME_BITS-1:0]  time_now;
  logic [CNT_BITS-1:0]   hits;
  logic [CNT_BITS-1:0]   misses;

  op_t                   op;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  logic [SECS_BITS-1:0]  secs;
  logic [PROD_BITS-1:0]  prod;
  logic                  exp_hit;
  logic [RW-1:0]         exp_slot;
  logic                  res_found;
  logic [VALUE_BITS-1:0] res_value;

  logic [DEPTH-1:0]      match;
  logic [DEPTH-1:0]      expired;
  logic                  hit;
  logic [RW-1:0]         hit_idx;
  logic                  any_exp;
  logic [RW-1:0]         exp_idx;
  logic [RW-1:0]         free_idx;
  logic [RW-1:0]         lru_idx;
  logic [CW-1:0]         cap_eff;
  logic                  need_evict;
  logic [TPS_BITS-1:0]   tps_eff;
  logic [TIME_BITS:0]    exp_sum;
  logic                  out_load;

  always_comb begin
    hit_idx  = '0;
    exp_idx  = '0;
    free_idx = '0;
    lru_idx  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      match[i]   = valid[i] && (keys[i] == key);
      expired[i] = valid[i] && exp_set[i] && (time_now > exp_time[i]);
      if (match[i]) begin
        hit_idx = RW'(i);
      end
      if (expired[i]) begin
        exp_idx = RW'(i);
      end
      if (!valid[i]) begin
        free_idx = RW'(i);
      end
      if (valid[i] && (rank[i] == RW'(count - CW'(1)))) begin
        lru_idx = RW'(i);
      end
    end
    hit     = |match;
    any_exp = |expired;
  end

  always_comb begin
    if (cfg.capacity == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cfg.capacity) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cfg.capacity);
    end
    need_evict = (count >= cap_eff);
    tps_eff    = (cfg.tps == '0) ? TPS_BITS'(1) : cfg.tps;
    exp_sum    = {1'b0, time_now} + (TIME_BITS + 1)'(prod);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd_op == OP_PUT || cmd_op == OP_GET) ? ST_PURGE : ST_EXEC;
        end
      end
      ST_PURGE: begin
        if (!any_exp) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op == OP_EXPIRE) begin
          state_next = ST_EXPIRE;
        end else if (!(op == OP_PUT && !hit && need_evict)) begin
          state_next = ST_DONE;
        end
      end
      ST_EXPIRE: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = (state == ST_IDLE) && cmd_valid;
    out_load = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found      <= res_found;
      value_out  <= res_value;
      hit_count  <= hits;
      miss_count <= misses;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      op    <= cmd_op;
      key   <= cmd_key;
      value <= cmd_value;
      secs  <= cmd_secs;
    end
    if (state == ST_EXEC && op == OP_EXPIRE) begin
      prod     <= PROD_BITS'(secs) * PROD_BITS'(tps_eff);
      exp_hit  <= hit;
      exp_slot <= hit_idx;
    end
    if (state == ST_EXPIRE && exp_hit) begin
      exp_time[exp_slot] <= exp_sum[TIME_BITS] ? TIME_MAX : exp_sum[TIME_BITS-1:0];
    end
    if (state == ST_EXEC && op == OP_PUT && hit) begin
      vals[hit_idx] <= value;
    end
    if (state == ST_EXEC && op == OP_PUT && !hit && !need_evict) begin
      keys[free_idx] <= key;
      vals[free_idx] <= value;
    end
    if (cmd_pop) begin
      res_found <= 1'b0;
      res_value <= '0;
    end else if (state == ST_EXEC) begin
      if (op == OP_GET && hit) begin
        res_found <= 1'b1;
        res_value <= vals[hit_idx];
      end else if (op == OP_EXISTS) begin
        res_found <= hit && !(|(match & expired));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        valid[i]   <= 1'b0;
        exp_set[i] <= 1'b0;
        rank[i]    <= '0;
      end
      count    <= '0;
      time_now <= '0;
      hits     <= '0;
      misses   <= '0;
    end else begin
      case (state)
        ST_PURGE: begin
          if (any_exp) begin
            for (int i = 0; i < DEPTH; i++) begin
              if (valid[i] && i != int'(exp_idx) && rank[i] > rank[exp_idx]) begin
                rank[i] <= rank[i] - RW'(1);
              end
            end
            valid[exp_idx]   <= 1'b0;
            exp_set[exp_idx] <= 1'b0;
            rank[exp_idx]    <= '0;
            count            <= count - CW'(1);
          end
        end
        ST_EXEC: begin
          case (op)
            OP_PUT, OP_GET: begin
              if (hit) begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (valid[i] && i != int'(hit_idx) && rank[i] < rank[hit_idx]) begin
                    rank[i] <= rank[i] + RW'(1);
                  end
                end
                rank[hit_idx] <= '0;
                if (op == OP_GET && hits != CNT_MAX) begin
                  hits <= hits + CNT_BITS'(1);
                end
              end else if (op == OP_GET) begin
                if (misses != CNT_MAX) begin
                  misses <= misses + CNT_BITS'(1);
                end
              end else if (need_evict) begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (valid[i] && i != int'(lru_idx) && rank[i] > rank[lru_idx]) begin
                    rank[i] <= rank[i] - RW'(1);
                  end
                end
                valid[lru_idx]   <= 1'b0;
                exp_set[lru_idx] <= 1'b0;
                rank[lru_idx]    <= '0;
                count            <= count - CW'(1);
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (valid[i]) begin
                    rank[i] <= rank[i] + RW'(1);
                  end
                end
                valid[free_idx]   <= 1'b1;
                exp_set[free_idx] <= 1'b0;
                rank[free_idx]    <= '0;
                count             <= count + CW'(1);
              end
            end
            OP_ERASE: begin
              if (hit) begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (valid[i] && i != int'(hit_idx) && rank[i] > rank[hit_idx]) begin
                    rank[i] <= rank[i] - RW'(1);
                  end
                end
                valid[hit_idx]   <= 1'b0;
                exp_set[hit_idx] <= 1'b0;
                rank[hit_idx]    <= '0;
                count            <= count - CW'(1);
              end
            end
            OP_TICK: begin
              if (time_now != TIME_MAX) begin
                time_now <= time_now + TIME_BITS'(1);
              end
            end
            default: begin
            end
          endcase
        end
        ST_EXPIRE: begin
          if (exp_hit) begin
            exp_set[exp_slot] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// LRU cache with expiry: testbench
// Drives commands on the input channel and checks every result transfer
// against a built-in predictor of the store, its recency order, expiry and
// counters. The run covers directed cases, several configuration settings,
// back pressure and random traffic on a small key space.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lrue_pkg::*;

  localparam int NSLOT = 16;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        found;
    logic [31:0] value;
    logic [31:0] hits;
    logic [31:0] misses;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_BITS-1:0] operation = '0;
  logic [31:0] lookup_key = '0;
  logic [31:0] value_in = '0;
  logic [SECS_BITS-1:0] seconds = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic [31:0] value_out, hit_count, miss_count;

  lru_cache_with_expiry_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .lookup_key(lookup_key), .value_in(value_in),
    .seconds(seconds), .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .value_out(value_out), .hit_count(hit_count),
    .miss_count(miss_count)
  );

  initial forever #2 clk = ~clk;

  initial begin
    #50ms;
    $display("tb: errors");
    $finish;
  end

  // Predictor state.
  logic        m_valid [NSLOT];
  logic [31:0] m_key [NSLOT];
  logic [31:0] m_val [NSLOT];
  logic        m_exp_on [NSLOT];
  logic [47:0] m_exp_at [NSLOT];
  int          m_rank [NSLOT];
  logic [47:0] m_now;
  logic [31:0] m_hits, m_misses;
  logic [4:0]  m_cap;
  logic [20:0] m_tps;

  answer_t pending_answers[$];
  int mismatches = 0;
  int transfers_seen = 0;
  int hold_cycles = 0;
  bit rx_random = 1'b1;

  function automatic bit expired(int s);
    return m_exp_on[s] && m_now > m_exp_at[s];
  endfunction

  function automatic int lookup(logic [31:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (m_valid[i] && m_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int s);
    for (int i = 0; i < NSLOT; i++)
      if (m_valid[i] && i != s && m_rank[i] > m_rank[s]) m_rank[i]--;
    m_valid[s] = 1'b0;
    m_exp_on[s] = 1'b0;
    m_rank[s] = 0;
  endfunction

  function automatic void promote(int s);
    for (int i = 0; i < NSLOT; i++)
      if (m_valid[i] && i != s && m_rank[i] < m_rank[s]) m_rank[i]++;
    m_rank[s] = 0;
  endfunction

  function automatic void purge_stale();
    for (int i = 0; i < NSLOT; i++)
      if (m_valid[i] && expired(i)) drop_slot(i);
  endfunction

  function automatic void insert_key(logic [31:0] k, logic [31:0] v);
    int lim, n, oldest, free_slot;
    lim = (m_cap == 0) ? 1 : (m_cap > NSLOT ? NSLOT : m_cap);
    forever begin
      n = 0;
      oldest = -1;
      for (int i = 0; i < NSLOT; i++)
        if (m_valid[i]) begin
          n++;
          if (oldest < 0 || m_rank[i] > m_rank[oldest]) oldest = i;
        end
      if (n < lim) break;
      drop_slot(oldest);
    end
    free_slot = -1;
    for (int i = 0; i < NSLOT; i++)
      if (m_valid[i]) m_rank[i]++;
      else if (free_slot < 0) free_slot = i;
    m_valid[free_slot] = 1'b1;
    m_key[free_slot] = k;
    m_val[free_slot] = v;
    m_exp_on[free_slot] = 1'b0;
    m_exp_at[free_slot] = '0;
    m_rank[free_slot] = 0;
  endfunction

  function automatic answer_t apply_command(logic [2:0] op, logic [31:0] k,
                                            logic [31:0] v, logic [15:0] secs);
    answer_t a;
    int s;
    logic [63:0] t;
    a = '0;
    case (op)
      OP_PUT: begin
        purge_stale();
        s = lookup(k);
        if (s >= 0) begin
          m_val[s] = v;
          promote(s);
        end else begin
          insert_key(k, v);
        end
      end
      OP_GET: begin
        purge_stale();
        s = lookup(k);
        if (s >= 0) begin
          a.found = 1'b1;
          a.value = m_val[s];
          promote(s);
          if (m_hits != 32'hFFFF_FFFF) m_hits++;
        end else if (m_misses != 32'hFFFF_FFFF) begin
          m_misses++;
        end
      end
      OP_ERASE: begin
        s = lookup(k);
        if (s >= 0) drop_slot(s);
      end
      OP_EXISTS: begin
        s = lookup(k);
        if (s >= 0 && !expired(s)) a.found = 1'b1;
      end
      OP_EXPIRE: begin
        s = lookup(k);
        if (s >= 0) begin
          t = 64'(m_now) + 64'(secs) * 64'((m_tps == 0) ? 21'd1 : m_tps);
          m_exp_on[s] = 1'b1;
          m_exp_at[s] = (t > 64'(TMAX)) ? TMAX : t[47:0];
        end
      end
      OP_TICK: if (m_now != TMAX) m_now++;
      default: ;
    endcase
    a.hits = m_hits;
    a.misses = m_misses;
    return a;
  endfunction

  task automatic send_command(logic [2:0] op, logic [31:0] k,
                              logic [31:0] v, logic [15:0] secs, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    lookup_key <= k;
    value_in <= v;
    seconds <= secs;
    pending_answers.push_back(apply_command(op, k, v, secs));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_answers.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [20:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAPACITY) m_cap = data[4:0];
    else m_tps = data;
  endtask

  // Result checker.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      transfers_seen++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        want = pending_answers.pop_front();
        if (found !== want.found || value_out !== want.value ||
            hit_count !== want.hits || miss_count !== want.misses) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0b %h %0d %0d got %0b %h %0d %0d",
                     want.found, want.value, want.hits, want.misses,
                     found, value_out, hit_count, miss_count);
        end
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request.
  initial begin
    int wait_n;
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      wait_n = rx_random ? $urandom_range(0, 11) : 0;
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  task automatic test_directed();
    send_command(OP_GET, 32'h0, 32'h0, 16'h0, 0);
    send_command(OP_PUT, 32'h0, 32'hFFFF_FFFF, 16'h0, 0);
    send_command(OP_PUT, 32'hFFFF_FFFF, 32'h0, 16'h0, 0);
    send_command(OP_GET, 32'hFFFF_FFFF, 32'h0, 16'h0, 0);
    send_command(OP_EXISTS, 32'h0, 32'h0, 16'h0, 0);
    send_command(OP_PUT, 32'h0, 32'hA5A5_5A5A, 16'h0, 0);
    send_command(OP_GET, 32'h0, 32'h0, 16'h0, 0);
    send_command(OP_EXPIRE, 32'h0, 32'h0, 16'd1, 0);
    send_command(OP_EXPIRE, 32'h1234, 32'h0, 16'd1, 0);
    send_command(OP_TICK, 32'h0, 32'h0, 16'h0, 0);
    send_command(OP_EXISTS, 32'h0, 32'h0, 16'h0, 0);
    send_command(OP_TICK, 32'h0, 32'h0, 16'h0, 0);
    send_command(OP_EXISTS, 32'h0, 32'h0, 16'h0, 0);
    send_command(OP_EXPIRE, 32'h0, 32'h0, 16'd0, 0);
    send_command(OP_GET, 32'h0, 32'h0, 16'h0, 0);
    send_command(OP_EXPIRE, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 0);
    send_command(OP_ERASE, 32'hFFFF_FFFF, 32'h0, 16'h0, 0);
    send_command(OP_ERASE, 32'hFFFF_FFFF, 32'h0, 16'h0, 0);
    send_command(3'd6, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 0);
    send_command(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0);
    send_command(OP_GET, 32'hFFFF_FFFF, 32'h0, 16'h0, 0);
  endtask

  task automatic test_capacity_eviction(logic [4:0] cap);
    write_register(CFG_CAPACITY, 21'(cap));
    for (int i = 0; i < 20; i++)
      send_command(OP_PUT, 32'(i), $urandom, 16'h0, 1);
    for (int i = 0; i < 20; i++)
      send_command(OP_GET, 32'(i), 32'h0, 16'h0, 1);
  endtask

  task automatic test_random(int n, int keys);
    logic [2:0] op;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: op = OP_PUT;
        6, 7, 8, 9, 10: op = OP_GET;
        11, 12: op = OP_ERASE;
        13, 14: op = OP_EXISTS;
        15, 16: op = OP_EXPIRE;
        17, 18: op = OP_TICK;
        default: op = 3'($urandom_range(0, 7));
      endcase
      k = ($urandom_range(0, 15) == 0) ? $urandom : 32'($urandom_range(0, keys - 1));
      send_command(op, k, $urandom, ($urandom_range(0, 7) == 0) ?
                   16'($urandom) : 16'($urandom_range(0, 3)), 1);
    end
  endtask

  task automatic test_back_pressure();
    hold_cycles = 300;
    for (int i = 0; i < 30; i++)
      send_command(OP_PUT, 32'($urandom_range(0, 7)), $urandom, 16'h0, 0);
    drain();
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      m_valid[i] = 1'b0; m_key[i] = '0; m_val[i] = '0;
      m_exp_on[i] = 1'b0; m_exp_at[i] = '0; m_rank[i] = 0;
    end
    m_now = '0; m_hits = '0; m_misses = '0;
    m_cap = 5'd16; m_tps = 21'd1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_capacity_eviction(5'd0);
    test_capacity_eviction(5'd31);
    test_capacity_eviction(5'd3);
    write_register(CFG_TICKS, 21'h1F_FFFF);
    test_random(150, 24);
    write_register(CFG_TICKS, 21'd0);
    test_random(150, 24);
    test_back_pressure();
    write_register(CFG_TICKS, 21'd1);
    write_register(CFG_CAPACITY, 21'd1);
    test_random(150, 6);
    write_register(CFG_CAPACITY, 21'd16);
    test_random(500, 24);
    write_register(CFG_CAPACITY, 21'd5);
    write_register(CFG_TICKS, 21'd2);
    test_random(400, 12);
    drain();
    $display("Covered directed cases, capacities 0, 1, 3, 5, 16 and 31,");
    $display("tick rates 0, 1, 2 and max, and %0d result transfers.", transfers_seen);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
